// ===== rtl/evpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evpu_pkg
// Types, constants and character-class helpers shared by the extended value
// percent/utf-8 decoder.
// ----------------------------------------------------------------------------
package evpu_pkg;

  typedef enum logic [1:0] {
    PH_CHARSET = 2'd0,
    PH_LANG    = 2'd1,
    PH_VALUE   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       status_done;
    logic       value_ok;
  } res_t;

  localparam int unsigned  CNT_W      = 17;
  localparam logic [16:0]  COUNT_MAX  = 17'h1FFFF;
  localparam logic [16:0]  BUF_RESET  = 17'd256;
  localparam logic [2:0]   CS_LEN     = 3'd5;

  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_SURR   = 8'hED;
  localparam logic [7:0] E0_CONT_MIN = 8'hA0;
  localparam logic [7:0] ED_CONT_MAX = 8'h9F;
  localparam logic [7:0] F0_CONT_MIN = 8'h90;
  localparam logic [7:0] F4_CONT_MAX = 8'h8F;
  localparam logic [7:0] ASCII_MAX   = 8'h7F;

  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DASH    = 8'h2D;

  // charset name in both letter cases
  function automatic logic cs_match(input logic [2:0] pos, input logic [7:0] c);
    logic [7:0] up;
    logic [7:0] lo;
    up = 8'h00;
    lo = 8'h00;
    unique case (pos)
      3'd0:    begin up = 8'h55; lo = 8'h75; end
      3'd1:    begin up = 8'h54; lo = 8'h74; end
      3'd2:    begin up = 8'h46; lo = 8'h66; end
      3'd3:    begin up = 8'h2D; lo = 8'h2D; end
      3'd4:    begin up = 8'h38; lo = 8'h38; end
      default: begin up = 8'h00; lo = 8'h00; end
    endcase
    return (pos < CS_LEN) && ((c == up) || (c == lo));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_attr(input logic [7:0] c);
    return is_alnum(c) || c == 8'h21 || c == 8'h23 || c == 8'h24 ||
           c == 8'h26 || c == 8'h2B || c == 8'h2D || c == 8'h2E ||
           c == 8'h5E || c == 8'h5F || c == 8'h60 || c == 8'h7C ||
           c == 8'h7E;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ===== rtl/evpu_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evpu channel interfaces
// Valid/ready channels for raw characters, results and the size register.
// ----------------------------------------------------------------------------
interface evpu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  logic       quoted_flag;
  modport source (output valid, in_byte, last_byte, quoted_flag, input ready);
  modport sink   (input valid, in_byte, last_byte, quoted_flag, output ready);
endinterface

interface evpu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       status_done;
  logic       value_ok;
  modport source (output valid, out_byte, byte_present, status_done, value_ok,
                  input ready);
  modport sink   (input valid, out_byte, byte_present, status_done, value_ok,
                  output ready);
endinterface

interface evpu_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] buffer_size;
  modport source (output valid, buffer_size, input ready);
  modport sink   (input valid, buffer_size, output ready);
endinterface

// ===== rtl/ext_value_percent_utf8_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext_value_percent_utf8_decoder_core
// Streaming check and decode of charset'lang'value with %HH escapes and
// utf-8 validation; emits decoded bytes and one status beat per value.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   in_ch     sink       in_byte, last_byte, quoted_flag
//   out_ch    source     out_byte, byte_present, status_done, value_ok
//   cfg_ch    sink       buffer_size (always ready)
//
// one character per cycle while in_ch.ready is high; the decode and utf-8 checks
// sit between the run state and a four-entry result queue of registered beats.
// a last character that also yields a byte pushes two beats; the queue drains
// one beat per cycle when out_ch is ready, so in_ch.ready needs two free slots.
// reset (synchronous, rst_n low) empties the queue, clears the run state and
// sets buffer_size to 256. out_ch stalls back up into in_ch through the queue.
// ----------------------------------------------------------------------------
module ext_value_percent_utf8_decoder_core
  import evpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  evpu_in_if.sink    in_ch,
  evpu_out_if.source out_ch,
  evpu_cfg_if.sink   cfg_ch
);

  // run state
  phase_t      phase_r,    phase_nxt;
  logic [2:0]  cs_pos_r,   cs_pos_nxt;
  esc_t        esc_r,      esc_nxt;
  logic [3:0]  hi_nib_r,   hi_nib_nxt;
  logic [1:0]  pend_r,     pend_nxt;
  logic [7:0]  lead_r,     lead_nxt;
  logic        first_r,    first_nxt;
  logic [16:0] count_r,    count_nxt;
  logic        failed_r,   failed_nxt;
  logic [16:0] buf_size_r;

  // result queue
  res_t        q_mem_r [4];
  logic [1:0]  q_wr_r, q_rd_r;
  logic [2:0]  q_cnt_r, q_cnt_nxt;

  logic        in_fire, out_fire;
  logic        have;
  logic [7:0]  dec;
  logic        ok;
  logic [1:0]  n_push;
  res_t        res0, res1;
  logic [7:0]  c;

  assign c        = in_ch.in_byte;
  assign in_ch.ready  = (q_cnt_r <= 3'd2);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_ch.valid & out_ch.ready;

  always_comb begin
    phase_nxt  = phase_r;
    cs_pos_nxt = cs_pos_r;
    esc_nxt    = esc_r;
    hi_nib_nxt = hi_nib_r;
    pend_nxt   = pend_r;
    lead_nxt   = lead_r;
    first_nxt  = first_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    have       = 1'b0;
    dec        = 8'h00;
    ok         = 1'b0;
    if (in_fire) begin
      if (in_ch.quoted_flag) begin
        failed_nxt = 1'b1;
      end
      if (!failed_nxt) begin
        unique case (phase_r)
          PH_CHARSET: begin
            if (c == CH_APOS) begin
              if (cs_pos_r == CS_LEN) phase_nxt = PH_LANG;
              else failed_nxt = 1'b1;
            end else if (!cs_match(cs_pos_r, c)) begin
              failed_nxt = 1'b1;
            end else begin
              cs_pos_nxt = cs_pos_r + 3'd1;
            end
          end
          PH_LANG: begin
            if (c == CH_APOS) phase_nxt = PH_VALUE;
            else if (!(is_alnum(c) || c == CH_DASH)) failed_nxt = 1'b1;
          end
          default: begin
            if (esc_r == ESC_IDLE) begin
              if (c == CH_PERCENT) begin
                esc_nxt = ESC_HIGH;
              end else if (is_attr(c)) begin
                have = 1'b1;
                dec  = c;
              end else begin
                failed_nxt = 1'b1;
              end
            end else if (!is_hex(c)) begin
              failed_nxt = 1'b1;
            end else if (esc_r == ESC_HIGH) begin
              hi_nib_nxt = hex_val(c);
              esc_nxt    = ESC_LOW;
            end else begin
              dec     = {hi_nib_r, hex_val(c)};
              have    = 1'b1;
              esc_nxt = ESC_IDLE;
            end
            // utf-8 check of the decoded byte
            if (have) begin
              if (dec == 8'h00) begin
                failed_nxt = 1'b1;
              end else if (pend_r == 2'd0) begin
                if (dec > ASCII_MAX) begin
                  lead_nxt  = dec;
                  first_nxt = 1'b1;
                  if (dec >= LEAD2_MIN && dec <= LEAD2_MAX) pend_nxt = 2'd1;
                  else if (dec >= LEAD3_MIN && dec <= LEAD3_MAX) pend_nxt = 2'd2;
                  else if (dec >= LEAD4_MIN && dec <= LEAD4_MAX) pend_nxt = 2'd3;
                  else failed_nxt = 1'b1;
                end
              end else if (dec[7:6] != 2'b10) begin
                failed_nxt = 1'b1;
              end else if (first_r && ((lead_r == LEAD3_MIN && dec < E0_CONT_MIN) ||
                                       (lead_r == LEAD_SURR && dec > ED_CONT_MAX) ||
                                       (lead_r == LEAD4_MIN && dec < F0_CONT_MIN) ||
                                       (lead_r == LEAD4_MAX && dec > F4_CONT_MAX))) begin
                failed_nxt = 1'b1;
              end else begin
                first_nxt = 1'b0;
                pend_nxt  = pend_r - 2'd1;
              end
              if (failed_nxt) begin
                have = 1'b0;
              end else if (count_r != COUNT_MAX) begin
                count_nxt = count_r + 17'd1;
              end
            end
          end
        endcase
      end
      if (in_ch.last_byte) begin
        ok = !failed_nxt && phase_nxt == PH_VALUE && esc_nxt == ESC_IDLE &&
             pend_nxt == 2'd0 && count_nxt < buf_size_r;
        phase_nxt  = PH_CHARSET;
        cs_pos_nxt = 3'd0;
        esc_nxt    = ESC_IDLE;
        hi_nib_nxt = 4'd0;
        pend_nxt   = 2'd0;
        lead_nxt   = 8'h00;
        first_nxt  = 1'b0;
        count_nxt  = 17'd0;
        failed_nxt = 1'b0;
      end
    end
  end

  // results of this beat, byte first then status
  always_comb begin
    res1 = '{out_byte: 8'h00, byte_present: 1'b0, status_done: 1'b1, value_ok: ok};
    if (have) begin
      res0 = '{out_byte: dec, byte_present: 1'b1, status_done: 1'b0, value_ok: 1'b0};
    end else begin
      res0 = res1;
    end
    n_push = {1'b0, have} + {1'b0, in_fire & in_ch.last_byte};
    q_cnt_nxt = q_cnt_r + {1'b0, n_push} - {2'b00, out_fire};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CHARSET;
      cs_pos_r   <= 3'd0;
      esc_r      <= ESC_IDLE;
      hi_nib_r   <= 4'd0;
      pend_r     <= 2'd0;
      lead_r     <= 8'h00;
      first_r    <= 1'b0;
      count_r    <= 17'd0;
      failed_r   <= 1'b0;
      buf_size_r <= BUF_RESET;
      q_wr_r     <= 2'd0;
      q_rd_r     <= 2'd0;
      q_cnt_r    <= 3'd0;
    end else begin
      phase_r  <= phase_nxt;
      cs_pos_r <= cs_pos_nxt;
      esc_r    <= esc_nxt;
      hi_nib_r <= hi_nib_nxt;
      pend_r   <= pend_nxt;
      lead_r   <= lead_nxt;
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
      if (cfg_ch.valid) begin
        buf_size_r <= cfg_ch.buffer_size;
      end
      q_wr_r  <= q_wr_r + n_push;
      q_cnt_r <= q_cnt_nxt;
      if (out_fire) begin
        q_rd_r <= q_rd_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[q_wr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_mem_r[q_wr_r + 2'd1] <= res1;
    end
  end

  assign out_ch.valid        = (q_cnt_r != 3'd0);
  assign out_ch.out_byte     = q_mem_r[q_rd_r].out_byte;
  assign out_ch.byte_present = q_mem_r[q_rd_r].byte_present;
  assign out_ch.status_done  = q_mem_r[q_rd_r].status_done;
  assign out_ch.value_ok     = q_mem_r[q_rd_r].value_ok;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 3'd4)
    else $error("result queue overfilled");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.last_byte |=> phase_r == PH_CHARSET && count_r == 17'd0 &&
    !failed_r)
    else $error("run state not cleared after last beat");

  a_no_byte_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    failed_r |-> !have)
    else $error("byte emitted after failure");

  a_pend_in_value: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd0 |-> phase_r == PH_VALUE)
    else $error("utf-8 sequence open outside value part");

endmodule

// ===== dv/ext_value_percent_utf8_decoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext_value_percent_utf8_decoder_core_tb
// Streams extended parameter values through the decoder. The values are mostly
// well-formed with random content and some are mutated or pure noise. A
// scoreboard tracks the decode and utf-8 state of the value to predict every
// byte beat and status beat. The run uses several buffer sizes and four
// patterns of input idling and output stalls.
// ----------------------------------------------------------------------------
module ext_value_percent_utf8_decoder_core_tb;
  import evpu_pkg::*;

  class decode_scoreboard;
    logic [16:0] buf_size;
    phase_t      phase;
    logic [2:0]  cs_pos;
    esc_t        esc;
    logic [3:0]  hi_nib;
    logic [1:0]  cont_due;
    logic [7:0]  lead;
    bit          first_cont;
    logic [16:0] dec_count;
    bit          bad;
    res_t        due_beats[$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned values_ok;
    int unsigned values_rejected;

    function new();
      buf_size = BUF_RESET;
      mismatches = 0;
      bytes_checked = 0;
      values_ok = 0;
      values_rejected = 0;
      clear_value();
    endfunction

    function void clear_value();
      phase = PH_CHARSET;
      cs_pos = '0;
      esc = ESC_IDLE;
      hi_nib = '0;
      cont_due = '0;
      lead = '0;
      first_cont = 1'b0;
      dec_count = '0;
      bad = 1'b0;
    endfunction

    static function bit alnum_char(logic [7:0] c);
      return ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39);
    endfunction

    static function bit attr_char(logic [7:0] c);
      if (alnum_char(c)) return 1'b1;
      case (c)
        8'h21, 8'h23, 8'h24, 8'h26, 8'h2B, 8'h2D,
        8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // bit 4 set when the character is not a hex digit
    static function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        return {1'b0, c[3:0] + 4'd9};
      return 5'h10;
    endfunction

    static function bit charset_char(logic [2:0] pos, logic [7:0] c);
      case (pos)
        3'd0: return (c | 8'h20) == 8'h75;
        3'd1: return (c | 8'h20) == 8'h74;
        3'd2: return (c | 8'h20) == 8'h66;
        3'd3: return c == 8'h2D;
        3'd4: return c == 8'h38;
        default: return 1'b0;
      endcase
    endfunction

    function bit utf8_takes(logic [7:0] b);
      if (cont_due == 0) begin
        if (b <= ASCII_MAX) return 1'b1;
        lead = b;
        first_cont = 1'b1;
        if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          cont_due = 2'd1;
          return 1'b1;
        end
        if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          cont_due = 2'd2;
          return 1'b1;
        end
        if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          cont_due = 2'd3;
          return 1'b1;
        end
        return 1'b0;
      end
      if (b[7:6] != 2'b10) return 1'b0;
      // overlong, surrogate and above-range bounds on the first continuation
      if (first_cont && ((lead == LEAD3_MIN && b < E0_CONT_MIN) ||
                         (lead == LEAD_SURR && b > ED_CONT_MAX) ||
                         (lead == LEAD4_MIN && b < F0_CONT_MIN) ||
                         (lead == LEAD4_MAX && b > F4_CONT_MAX)))
        return 1'b0;
      first_cont = 1'b0;
      cont_due = cont_due - 2'd1;
      return 1'b1;
    endfunction

    // returns 1 when the character was acted on rather than ignored
    function bit take_char(logic [7:0] c, bit is_last, bit quoted);
      bit         live;
      bit         have;
      bit         ok;
      logic [7:0] dec;
      logic [4:0] nib;
      res_t       beat;
      live = !bad;
      have = 1'b0;
      dec = '0;
      if (quoted) bad = 1'b1;
      if (!bad) begin
        case (phase)
          PH_CHARSET: begin
            if (c == CH_APOS) begin
              if (cs_pos == CS_LEN) phase = PH_LANG;
              else bad = 1'b1;
            end else if (!charset_char(cs_pos, c)) begin
              bad = 1'b1;
            end else begin
              cs_pos++;
            end
          end
          PH_LANG: begin
            if (c == CH_APOS) phase = PH_VALUE;
            else if (!(alnum_char(c) || c == CH_DASH)) bad = 1'b1;
          end
          default: begin
            if (esc == ESC_IDLE) begin
              if (c == CH_PERCENT) esc = ESC_HIGH;
              else if (attr_char(c)) begin
                have = 1'b1;
                dec = c;
              end else bad = 1'b1;
            end else begin
              nib = nibble_of(c);
              if (nib[4]) begin
                bad = 1'b1;
              end else if (esc == ESC_HIGH) begin
                hi_nib = nib[3:0];
                esc = ESC_LOW;
              end else begin
                dec = {hi_nib, nib[3:0]};
                have = 1'b1;
                esc = ESC_IDLE;
              end
            end
            if (have) begin
              if (dec == 8'h00 || !utf8_takes(dec)) begin
                bad = 1'b1;
                have = 1'b0;
              end else if (dec_count != COUNT_MAX) begin
                dec_count++;
              end
            end
          end
        endcase
      end
      if (have) begin
        beat.out_byte = dec;
        beat.byte_present = 1'b1;
        beat.status_done = 1'b0;
        beat.value_ok = 1'b0;
        due_beats.push_back(beat);
      end
      if (is_last) begin
        ok = !bad && phase == PH_VALUE && esc == ESC_IDLE && cont_due == 0 &&
             dec_count < buf_size;
        beat.out_byte = '0;
        beat.byte_present = 1'b0;
        beat.status_done = 1'b1;
        beat.value_ok = ok;
        due_beats.push_back(beat);
        clear_value();
      end
      return live;
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %02h present %0b status %0b ok %0b",
               got.out_byte, got.byte_present, got.status_done, got.value_ok);
        mismatches++;
        return;
      end
      want = due_beats.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.byte_present !== want.byte_present) begin
        $error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
        mismatches++;
      end
      if (got.status_done !== want.status_done) begin
        $error("status_done: expected %0b, got %0b", want.status_done, got.status_done);
        mismatches++;
      end
      if (got.value_ok !== want.value_ok) begin
        $error("value_ok: expected %0b, got %0b", want.value_ok, got.value_ok);
        mismatches++;
      end
      if (want.byte_present) bytes_checked++;
      if (want.status_done) begin
        if (want.value_ok) values_ok++;
        else values_rejected++;
      end
    endfunction
  endclass

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IN_IDLE_PCT[4]   = '{0, 81, 0, 23};
  localparam int unsigned OUT_STALL_PCT[4] = '{0, 0, 81, 23};
  localparam logic [7:0] CS_NAME[5]   = '{8'h55, 8'h54, 8'h46, 8'h2D, 8'h38};
  localparam logic [7:0] ATTR_SYM[12] = '{8'h21, 8'h23, 8'h24, 8'h26, 8'h2B, 8'h2D,
                                          8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E};

  logic clk = 1'b0;
  logic rst_n;

  evpu_in_if  in_ch();
  evpu_out_if out_ch();
  evpu_cfg_if cfg_ch();

  ext_value_percent_utf8_decoder_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  decode_scoreboard sb;
  int unsigned      in_idle_pct;
  int unsigned      out_stall_pct;
  int unsigned      live_chars;
  int unsigned      values_sent;
  logic [7:0]       text[$];
  int               quote_at;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.out_byte, out_ch.byte_present, out_ch.status_done,
                     out_ch.value_ok});
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + n;
    return (lower ? 8'h57 : 8'h37) + n;
  endfunction

  function automatic logic [7:0] pick_attr(bit alnum_only);
    case ($urandom_range(0, alnum_only ? 2 : 3))
      0: return 8'h41 + 8'($urandom_range(0, 25));
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      default: return ATTR_SYM[$urandom_range(0, 11)];
    endcase
  endfunction

  // biased towards the ends of the range
  function automatic logic [7:0] pick_cont(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(0, 2))
      0: return lo;
      1: return hi;
      default: return 8'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic void add_escape(logic [7:0] b);
    text.push_back(CH_PERCENT);
    text.push_back(hex_char(b[7:4], coin()));
    text.push_back(hex_char(b[3:0], coin()));
  endfunction

  function automatic void add_byte(logic [7:0] b);
    if (decode_scoreboard::attr_char(b) && coin()) text.push_back(b);
    else add_escape(b);
  endfunction

  function automatic void add_charset(int unsigned len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      c = CS_NAME[i];
      if (i < 3 && coin()) c = c | 8'h20;
      text.push_back(c);
    end
  endfunction

  function automatic void add_seq();
    int unsigned n;
    logic [7:0]  lead;
    logic [7:0]  lo;
    logic [7:0]  hi;
    n = $urandom_range(1, 4);
    lo = 8'h80;
    hi = 8'hBF;
    case (n)
      1: lead = 8'($urandom_range(1, 127));
      2: lead = pick_cont(LEAD2_MIN, LEAD2_MAX);
      3: begin
        case ($urandom_range(0, 3))
          0: lead = LEAD3_MIN;
          1: lead = LEAD_SURR;
          default: lead = 8'($urandom_range(8'hE1, LEAD3_MAX));
        endcase
        if (lead == LEAD3_MIN) lo = E0_CONT_MIN;
        if (lead == LEAD_SURR) hi = ED_CONT_MAX;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: lead = LEAD4_MIN;
          1: lead = LEAD4_MAX;
          default: lead = 8'($urandom_range(8'hF1, 8'hF3));
        endcase
        if (lead == LEAD4_MIN) lo = F0_CONT_MIN;
        if (lead == LEAD4_MAX) hi = F4_CONT_MAX;
      end
    endcase
    add_byte(lead);
    if (n > 1) begin
      add_byte(pick_cont(lo, hi));
      repeat (n - 2) add_byte(pick_cont(8'h80, 8'hBF));
    end
  endfunction

  // zero byte, bad lead, first continuation outside its bound or not a continuation, or a lone lead
  function automatic void add_broken_seq();
    case ($urandom_range(0, 3))
      0: add_escape(8'h00);
      1: begin
        case ($urandom_range(0, 2))
          0: add_escape(8'($urandom_range(8'h80, 8'hBF)));
          1: add_escape(8'($urandom_range(8'hC0, 8'hC1)));
          default: add_escape(8'($urandom_range(8'hF5, 8'hFF)));
        endcase
      end
      2: begin
        case ($urandom_range(0, 4))
          0: begin add_escape(LEAD3_MIN); add_escape(E0_CONT_MIN - 8'd1); end
          1: begin add_escape(LEAD_SURR); add_escape(ED_CONT_MAX + 8'd1); end
          2: begin add_escape(LEAD4_MIN); add_escape(F0_CONT_MIN - 8'd1); end
          3: begin add_escape(LEAD4_MAX); add_escape(F4_CONT_MAX + 8'd1); end
          default: begin
            add_escape(pick_cont(LEAD2_MIN, LEAD2_MAX));
            add_byte(coin() ? 8'h7F : 8'hC0);
          end
        endcase
      end
      default: add_escape(8'($urandom_range(LEAD2_MIN, LEAD4_MAX)));
    endcase
  endfunction

  function automatic void build_value();
    int unsigned kind;
    int unsigned n;
    int unsigned k;
    text.delete();
    quote_at = -1;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      add_charset(5);
      text.push_back(CH_APOS);
      repeat ($urandom_range(0, 4))
        text.push_back($urandom_range(0, 5) == 0 ? CH_DASH : pick_attr(1'b1));
      text.push_back(CH_APOS);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n) begin
        if ($urandom_range(0, 2) == 0) text.push_back(pick_attr(1'b0));
        else add_seq();
      end
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 4))
          0: text[$urandom_range(0, text.size() - 1)] = rand_byte();
          1: begin
            k = $urandom_range(1, text.size() - 1);
            while (text.size() > k) void'(text.pop_back());
          end
          2: quote_at = $urandom_range(0, text.size() - 1);
          3: begin
            add_broken_seq();
            if (coin()) add_seq();
          end
          default: text.push_back(rand_byte());
        endcase
      end
    end else if (kind < 85) begin
      add_charset(5);
      text.push_back(CH_APOS);
      text.push_back(CH_APOS);
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 2))
          0: add_escape(rand_byte());
          1: begin
            text.push_back(CH_PERCENT);
            text.push_back(hex_char(4'($urandom_range(0, 15)), coin()));
            text.push_back(rand_byte());
          end
          default: text.push_back(rand_byte());
        endcase
      end
    end else begin
      // charset prefix then stray characters or apostrophes
      add_charset($urandom_range(0, 5));
      repeat ($urandom_range(1, 3))
        text.push_back($urandom_range(0, 2) == 0 ? CH_APOS : rand_byte());
      if ($urandom_range(0, 3) == 0) quote_at = $urandom_range(0, text.size() - 1);
    end
  endfunction

  task automatic send_char(logic [7:0] c, bit is_last, bit quoted);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= c;
    in_ch.last_byte   <= is_last;
    in_ch.quoted_flag <= quoted;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (sb.take_char(c, is_last, quoted)) live_chars++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++)
      send_char(text[i], i == text.size() - 1, i == quote_at);
    values_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [16:0] v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.buffer_size <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.buf_size = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int unsigned target;
    int unsigned half;
    bit          paused;
    logic [16:0] sizes[8];
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.last_byte = 1'b0;
    in_ch.quoted_flag = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.buffer_size = '0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    live_chars = 0;
    values_sent = 0;
    sizes = '{17'd1, 17'd65536, 17'd4, 17'd256, 17'd0, 17'd12, 17'd0, 17'd7};
    sizes[4] = 17'($urandom_range(2, 20));
    sizes[6] = 17'($urandom_range(1, 65536));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // quoted value, with the byte after the failure ignored
    text.delete();
    text.push_back(8'h00);
    text.push_back(8'hFF);
    quote_at = 0;
    send_text();
    // apostrophe before the charset is complete
    text.delete();
    quote_at = -1;
    put_str("'");
    send_text();
    // value ends in the language part
    text.delete();
    put_str("utf-8'");
    send_text();
    // highest code point, at the upper bound after an f4 lead
    text.delete();
    put_str("UTF-8'e'%F4%8F%BF%bf~");
    send_text();

    for (int p = 0; p < 4; p++) begin
      in_idle_pct = IN_IDLE_PCT[p];
      out_stall_pct = OUT_STALL_PCT[p];
      for (int s = 0; s < 2; s++) begin
        wait_drained();
        write_size(sizes[2 * p + s]);
        target = live_chars + 125;
        half = live_chars + 62;
        paused = (s != 0);
        while (live_chars < target) begin
          // hold off input until the output side has caught up
          if (!paused && live_chars >= half) begin
            wait_drained();
            paused = 1'b1;
          end
          build_value();
          send_text();
        end
      end
    end
    wait_drained();

    $display("covered %0d values, %0d characters acted on, %0d decoded bytes checked",
             values_sent, live_chars, sb.bytes_checked);
    $display("statuses: %0d valid, %0d rejected; 8 buffer sizes, 4 idle and stall mixes",
             sb.values_ok, sb.values_rejected);
    if (sb.mismatches == 0) begin
      $display("ext_value_percent_utf8_decoder_core_tb: done, clean");
    end else begin
      $display("ext_value_percent_utf8_decoder_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout waiting for the decoder");
    $display("ext_value_percent_utf8_decoder_core_tb: done, errors");
    $finish;
  end

endmodule
